@@ hw/rtl/lpg3d_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg3d_pkg
// Shared widths, codes and transfer types of the 3D line point generator.
// ----------------------------------------------------------------------------
package lpg3d_pkg;

    localparam int COORD_BITS = 16;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int INDEX_BITS = 16;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op                            op;
        logic signed [COORD_BITS-1:0]   start_x;
        logic signed [COORD_BITS-1:0]   start_y;
        logic signed [COORD_BITS-1:0]   start_z;
        logic signed [COORD_BITS-1:0]   end_x;
        logic signed [COORD_BITS-1:0]   end_y;
        logic signed [COORD_BITS-1:0]   end_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]   px;
        logic signed [COORD_BITS-1:0]   py;
        logic signed [COORD_BITS-1:0]   pz;
        logic [INDEX_BITS-1:0]          point_index;
        logic                           last;
    } t_out;

    typedef struct packed {
        logic capture;
        logic setup;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic active;
    } t_status;

endpackage

@@ hw/rtl/line_point_generator_3d.sv @@
// ----------------------------------------------------------------------------
// line_point_generator_3d
// Bresenham 3D line point generator: a load sets up a line and gives its
// start point, each step gives the next voxel until the end point.
// ----------------------------------------------------------------------------
//  channel   signals                  transfer
//  command   i_start, o_busy, i_in    edge with i_start high and o_busy low
//  result    o_valid, o_out           every edge with o_valid high
//
//  a step gives its point after acceptance through the emit state, then
//  o_valid for one cycle while o_busy is already low again
//  a load first passes through the set-up state for deltas and axis choice
//  a step with no line running is taken with o_busy staying low, no result
//  synchronous active-low reset clears the sequencer and the line-active flag
//  results cannot be held off: o_valid lasts exactly one cycle
// ----------------------------------------------------------------------------
module line_point_generator_3d (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lpg3d_pkg::t_in      i_in,
    output logic                o_busy,
    output logic                o_valid,
    output lpg3d_pkg::t_out     o_out
);

    lpg3d_pkg::t_cmd    cmd;
    lpg3d_pkg::t_status status;

    lpg3d_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_op     (i_in.op),
        .i_status (status),
        .o_busy   (o_busy),
        .o_cmd    (cmd)
    );

    lpg3d_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_out    (o_out)
    );

endmodule

@@ hw/rtl/lpg3d_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpg3d_ctrl
// Sequencer: takes commands, steers line set-up and point emission.
// ----------------------------------------------------------------------------
module lpg3d_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  lpg3d_pkg::t_op      i_op,
    input  lpg3d_pkg::t_status  i_status,
    output logic                o_busy,
    output lpg3d_pkg::t_cmd     o_cmd
);

    lpg3d_pkg::t_state r_state;
    lpg3d_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpg3d_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpg3d_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_op == lpg3d_pkg::OP_LOAD) begin
                        n_state = lpg3d_pkg::ST_SETUP;
                    end else if (i_status.active) begin
                        n_state = lpg3d_pkg::ST_EMIT;
                    end
                end
            end
            lpg3d_pkg::ST_SETUP: n_state = lpg3d_pkg::ST_EMIT;
            lpg3d_pkg::ST_EMIT:  n_state = lpg3d_pkg::ST_IDLE;
            default:             n_state = lpg3d_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy        = 1'b1;
        o_cmd.capture = 1'b0;
        o_cmd.setup   = 1'b0;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            lpg3d_pkg::ST_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
            end
            lpg3d_pkg::ST_SETUP: o_cmd.setup = 1'b1;
            lpg3d_pkg::ST_EMIT:  o_cmd.emit  = 1'b1;
            default:             o_busy      = 1'b1;
        endcase
    end

endmodule

@@ hw/rtl/lpg3d_dp.sv @@
// ----------------------------------------------------------------------------
// lpg3d_dp
// Datapath: endpoint capture, delta set-up, error terms and point register.
// ----------------------------------------------------------------------------
module lpg3d_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpg3d_pkg::t_in      i_in,
    input  lpg3d_pkg::t_cmd     i_cmd,
    output lpg3d_pkg::t_status  o_status,
    output logic                o_valid,
    output lpg3d_pkg::t_out     o_out
);

    localparam int CB = lpg3d_pkg::COORD_BITS;
    localparam int DB = lpg3d_pkg::DELTA_BITS;
    localparam int EB = lpg3d_pkg::ERR_BITS;
    localparam int IB = lpg3d_pkg::INDEX_BITS;

    lpg3d_pkg::t_in     r_in;
    logic [CB-1:0]      r_cur [3];
    logic [EB-1:0]      r_err1;
    logic [EB-1:0]      r_err2;
    logic [DB-1:0]      r_maj;
    logic [DB-1:0]      r_min1;
    logic [DB-1:0]      r_min2;
    logic [2:0]         r_neg;
    lpg3d_pkg::t_axis   r_major;
    logic [DB-1:0]      r_rem;
    logic [IB-1:0]      r_idx;
    logic               r_active;
    logic               r_valid;
    lpg3d_pkg::t_out    r_out;

    // set-up terms
    logic [DB-1:0]      d_x, d_y, d_z;
    logic [DB-1:0]      a_x, a_y, a_z;
    lpg3d_pkg::t_axis   n_major;
    logic [DB-1:0]      n_maj, n_min1, n_min2;

    // step terms
    logic [EB-1:0]      two_major;
    logic [EB-1:0]      sum1, sum2;
    logic               ge1, ge2;
    logic [EB-1:0]      n_err1, n_err2;
    logic [2:0]         maj_bit, min1_bit, min2_bit, mv;

    always_comb begin
        d_x = {r_in.end_x[CB-1], r_in.end_x} - {r_in.start_x[CB-1], r_in.start_x};
        d_y = {r_in.end_y[CB-1], r_in.end_y} - {r_in.start_y[CB-1], r_in.start_y};
        d_z = {r_in.end_z[CB-1], r_in.end_z} - {r_in.start_z[CB-1], r_in.start_z};
        a_x = d_x[DB-1] ? (~d_x + DB'(1)) : d_x;
        a_y = d_y[DB-1] ? (~d_y + DB'(1)) : d_y;
        a_z = d_z[DB-1] ? (~d_z + DB'(1)) : d_z;

        // ties favour x, then y
        if (a_x >= a_y && a_x >= a_z) begin
            n_major = lpg3d_pkg::AXIS_X;
        end else if (a_y >= a_z) begin
            n_major = lpg3d_pkg::AXIS_Y;
        end else begin
            n_major = lpg3d_pkg::AXIS_Z;
        end

        // first minor is the lower-numbered remaining axis
        unique case (n_major)
            lpg3d_pkg::AXIS_X: begin
                n_maj = a_x; n_min1 = a_y; n_min2 = a_z;
            end
            lpg3d_pkg::AXIS_Y: begin
                n_maj = a_y; n_min1 = a_x; n_min2 = a_z;
            end
            lpg3d_pkg::AXIS_Z: begin
                n_maj = a_z; n_min1 = a_x; n_min2 = a_y;
            end
            default: begin
                n_maj = a_x; n_min1 = a_y; n_min2 = a_z;
            end
        endcase
    end

    always_comb begin
        two_major = EB'({r_maj, 1'b0});
        sum1      = r_err1 + EB'({r_min1, 1'b0});
        sum2      = r_err2 + EB'({r_min2, 1'b0});
        ge1       = ~sum1[EB-1];
        ge2       = ~sum2[EB-1];
        n_err1    = ge1 ? (sum1 - two_major) : sum1;
        n_err2    = ge2 ? (sum2 - two_major) : sum2;

        unique case (r_major)
            lpg3d_pkg::AXIS_X: begin
                maj_bit = 3'b001; min1_bit = 3'b010; min2_bit = 3'b100;
            end
            lpg3d_pkg::AXIS_Y: begin
                maj_bit = 3'b010; min1_bit = 3'b001; min2_bit = 3'b100;
            end
            lpg3d_pkg::AXIS_Z: begin
                maj_bit = 3'b100; min1_bit = 3'b001; min2_bit = 3'b010;
            end
            default: begin
                maj_bit = 3'b001; min1_bit = 3'b010; min2_bit = 3'b100;
            end
        endcase
        mv = maj_bit | (ge1 ? min1_bit : 3'b000) | (ge2 ? min2_bit : 3'b000);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end

        if (i_cmd.setup) begin
            r_cur[0] <= r_in.start_x;
            r_cur[1] <= r_in.start_y;
            r_cur[2] <= r_in.start_z;
            r_err1   <= EB'(0) - EB'(n_maj);
            r_err2   <= EB'(0) - EB'(n_maj);
            r_maj    <= n_maj;
            r_min1   <= n_min1;
            r_min2   <= n_min2;
            r_neg    <= {d_z[DB-1], d_y[DB-1], d_x[DB-1]};
            r_major  <= n_major;
            r_rem    <= n_maj;
            r_idx    <= '0;
        end else if (i_cmd.emit && r_rem != '0) begin
            for (int a = 0; a < 3; a++) begin
                if (mv[a]) begin
                    r_cur[a] <= r_neg[a] ? (r_cur[a] - CB'(1)) : (r_cur[a] + CB'(1));
                end
            end
            r_err1 <= n_err1;
            r_err2 <= n_err2;
            r_rem  <= r_rem - DB'(1);
            r_idx  <= r_idx + IB'(1);
        end

        if (i_cmd.emit) begin
            r_out.px          <= r_cur[0];
            r_out.py          <= r_cur[1];
            r_out.pz          <= r_cur[2];
            r_out.point_index <= r_idx;
            r_out.last        <= (r_rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.setup) begin
                r_active <= 1'b1;
            end else if (i_cmd.emit && r_rem == '0) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_status.active = r_active;
    assign o_valid         = r_valid;
    assign o_out           = r_out;

endmodule

@@ bench/line_point_generator_3d_tb.sv @@
// ----------------------------------------------------------------------------
// line_point_generator_3d_tb
// Self-checking bench for the 3D line point generator: a directed set of
// lines (ties, all directions, extreme corners, single-point lines, steps with
// no line) and then random lines with random start gaps. Every accepted
// command is run through a local Bresenham model and each result is checked
// field by field against the oldest predicted point.
// ----------------------------------------------------------------------------
module line_point_generator_3d_tb;
    import lpg3d_pkg::*;

    typedef int t_triple [3];

    typedef struct {
        t_in cmd;
        bit  hold;
    } t_pending;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_in  cmd_bus = '0;
    logic o_busy;
    logic o_valid;
    t_out o_out;

    t_pending pending[$];
    t_out     points_expected[$];
    int       points_due = 0;
    int       points_planned = 0;
    int       mismatches = 0;
    int       sent = 0;

    // line state of the model
    logic signed [COORD_BITS-1:0] pos [3] = '{default: '0};
    logic [DELTA_BITS-1:0]        span [3] = '{default: '0};
    logic signed [ERR_BITS-1:0]   err_a = '0;
    logic signed [ERR_BITS-1:0]   err_b = '0;
    logic [2:0]                   neg_dir = '0;
    t_axis                        major = AXIS_X;
    logic [DELTA_BITS-1:0]        left = '0;
    logic [INDEX_BITS-1:0]        idx = '0;
    bit                           line_on = 1'b0;

    line_point_generator_3d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (cmd_bus),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_out   (o_out)
    );

    function automatic void advance_axis(t_axis a);
        pos[a] = neg_dir[a] ? pos[a] - COORD_BITS'(1) : pos[a] + COORD_BITS'(1);
    endfunction

    function automatic bit next_point(input t_in cmd, output t_out pt);
        logic signed [DELTA_BITS-1:0] d;
        logic signed [COORD_BITS-1:0] from [3];
        logic signed [COORD_BITS-1:0] to [3];
        logic signed [ERR_BITS-1:0]   two_major;
        t_axis m1;
        t_axis m2;
        pt = '0;
        if (cmd.op == OP_LOAD) begin
            from = '{cmd.start_x, cmd.start_y, cmd.start_z};
            to   = '{cmd.end_x, cmd.end_y, cmd.end_z};
            for (int a = 0; a < 3; a++) begin
                d = $signed({to[a][COORD_BITS-1], to[a]})
                    - $signed({from[a][COORD_BITS-1], from[a]});
                span[a]    = d[DELTA_BITS-1] ? DELTA_BITS'(-d) : DELTA_BITS'(d);
                neg_dir[a] = d[DELTA_BITS-1];
                pos[a]     = from[a];
            end
            if (span[0] >= span[1] && span[0] >= span[2]) begin
                major = AXIS_X;
            end else if (span[1] >= span[2]) begin
                major = AXIS_Y;
            end else begin
                major = AXIS_Z;
            end
            err_a   = -$signed({2'b00, span[major]});
            err_b   = err_a;
            left    = span[major];
            idx     = '0;
            line_on = 1'b1;
        end else if (!line_on) begin
            return 1'b0;
        end
        pt.px          = pos[0];
        pt.py          = pos[1];
        pt.pz          = pos[2];
        pt.point_index = idx;
        pt.last        = (left == 0);
        if (left == 0) begin
            line_on = 1'b0;
            return 1'b1;
        end
        // minor axes keep their x, y, z order
        m1 = (major == AXIS_X) ? AXIS_Y : AXIS_X;
        m2 = (major == AXIS_Z) ? AXIS_Y : AXIS_Z;
        two_major = $signed({1'b0, span[major], 1'b0});
        advance_axis(major);
        err_a = err_a + $signed({1'b0, span[m1], 1'b0});
        err_b = err_b + $signed({1'b0, span[m2], 1'b0});
        if (!err_a[ERR_BITS-1]) begin
            advance_axis(m1);
            err_a = err_a - two_major;
        end
        if (!err_b[ERR_BITS-1]) begin
            advance_axis(m2);
            err_b = err_b - two_major;
        end
        left = left - DELTA_BITS'(1);
        idx  = idx + INDEX_BITS'(1);
        return 1'b1;
    endfunction

    function automatic t_triple any_point();
        t_triple p;
        foreach (p[a]) p[a] = int'($urandom_range(65535)) - 32768;
        return p;
    endfunction

    function automatic t_in make_cmd(t_op op, t_triple s, t_triple e);
        t_in c;
        c.op      = op;
        c.start_x = COORD_BITS'(s[0]);
        c.start_y = COORD_BITS'(s[1]);
        c.start_z = COORD_BITS'(s[2]);
        c.end_x   = COORD_BITS'(e[0]);
        c.end_y   = COORD_BITS'(e[1]);
        c.end_z   = COORD_BITS'(e[2]);
        return c;
    endfunction

    function automatic int line_span(t_triple s, t_triple e);
        int d;
        int m;
        m = 0;
        foreach (s[a]) begin
            d = e[a] - s[a];
            if (d < 0) d = -d;
            if (d > m) m = d;
        end
        return m;
    endfunction

    // a load followed by a number of steps, which may run past the end point
    task automatic queue_line(t_triple s, t_triple e, int steps, bit hold);
        t_pending item;
        int len;
        len = line_span(s, e);
        item.cmd  = make_cmd(OP_LOAD, s, e);
        item.hold = hold;
        pending.push_back(item);
        for (int n = 0; n < steps; n++) begin
            item.cmd  = make_cmd(OP_STEP, any_point(), any_point());
            item.hold = 1'b0;
            pending.push_back(item);
        end
        points_planned += 1 + ((steps < len) ? steps : len);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        t_pending item;
        t_triple  s;
        t_triple  e;
        int       lim;
        int       len;
        int       steps;
        bit       wide;
        bit       first;

        // step with no line loaded yet
        item.cmd  = make_cmd(OP_STEP, any_point(), any_point());
        item.hold = 1'b0;
        pending.push_back(item);
        // equal endpoints, then a step after the last point
        queue_line('{5, 5, 5}, '{5, 5, 5}, 1, 1'b0);
        // x major tied with z, negative z, one step past the end
        queue_line('{0, 0, 0}, '{3, 2, -3}, 4, 1'b0);
        // y major tied with z, all negative
        queue_line('{10, 10, 10}, '{8, 7, 7}, 3, 1'b0);
        // z major
        queue_line('{-3, 1, 0}, '{-1, -1, 3}, 3, 1'b0);
        // three-way tie
        queue_line('{0, 0, 0}, '{2, -2, 2}, 2, 1'b0);
        // extreme corners, the two long lines abandoned by the next load
        queue_line('{-32768, -32768, -32768}, '{32767, 32767, 32767}, 3, 1'b0);
        queue_line('{32767, -32768, 32767}, '{-32768, 32767, -32768}, 2, 1'b0);
        queue_line('{32767, 32767, 32767}, '{32765, 32767, 32766}, 2, 1'b0);

        points_planned = 0;
        first = 1'b1;
        while (points_planned < 950) begin
            s    = any_point();
            wide = ($urandom_range(15) == 0);
            lim  = ($urandom_range(3) == 0) ? 60 : 8;
            if (wide) begin
                e = any_point();
            end else begin
                foreach (e[a]) begin
                    e[a] = s[a] + int'($urandom_range(2 * lim)) - lim;
                    if (e[a] > 32767 || e[a] < -32768) e[a] = 2 * s[a] - e[a];
                end
                if ($urandom_range(29) == 0) e = s;
            end
            len = line_span(s, e);
            if (wide) begin
                steps = $urandom_range(1, 10);
            end else begin
                case ($urandom_range(9))
                    0: steps = $urandom_range(len);
                    1: steps = len + $urandom_range(1, 3);
                    default: steps = len;
                endcase
            end
            queue_line(s, e, steps, first || ($urandom_range(24) == 0));
            first = 1'b0;
        end
    end

    // command driver
    always @(posedge i_clk) begin
        bit go;
        bit gaps;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || !o_busy) begin
            gaps = !(sent >= 300 && sent < 550);
            go = pending.size() > 0;
            // a held command waits until every point is out
            if (go && pending[0].hold &&
                (i_start || o_busy || o_valid || points_due != 0)) go = 1'b0;
            if (go && gaps && $urandom_range(99) < 30) go = 1'b0;
            if (go) begin
                i_start <= 1'b1;
                cmd_bus <= pending[0].cmd;
                pending.pop_front();
                sent++;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // result monitor and model
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (points_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected point %p", $time, o_out);
                end else begin
                    want = points_expected.pop_front();
                    check_field("px", 32'(want.px), 32'(o_out.px));
                    check_field("py", 32'(want.py), 32'(o_out.py));
                    check_field("pz", 32'(want.pz), 32'(o_out.pz));
                    check_field("point_index", 32'(want.point_index),
                                32'(o_out.point_index));
                    check_field("last", 32'(want.last), 32'(o_out.last));
                end
            end
            if (i_start && o_busy === 1'b0) begin
                if (next_point(cmd_bus, want)) points_expected.push_back(want);
            end
            points_due <= points_expected.size();
        end
    end

    initial begin
        wait (i_rst_n === 1'b1);
        do @(posedge i_clk);
        while (pending.size() != 0 || i_start || points_due != 0);
        repeat (10) @(posedge i_clk);
        if (points_expected.size() != 0) begin
            mismatches++;
            $display("%0t: %0d points never came", $time, points_expected.size());
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
